/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sch_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial cell hash table package
// Beat types, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package sch_pkg;

  localparam logic [31:0] PRIME_X   = 32'd73856093;
  localparam logic [31:0] PRIME_Y   = 32'd19349663;
  localparam logic [12:0] CFG_RESET = 13'd4096;
  localparam logic [4:0]  HASH_NIBBLES = 5'd16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_MULX,
    S_MULY,
    S_HASH,
    S_MWAIT,
    S_READ,
    S_EVAL,
    S_PRD,
    S_PEV,
    S_PLINK,
    S_UWAIT,
    S_URD,
    S_UEV,
    S_UFREE,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    ACT_MISS,
    ACT_HIT,
    ACT_FILL,
    ACT_UPDATE,
    ACT_FREE,
    ACT_NEXT,
    ACT_FULL,
    ACT_PROBE,
    ACT_PULL
  } act_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic [15:0]        new_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] value_out;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [4:0]  nibbles;
  } mod_req_t;

endpackage

/* rtl/core/sch_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 64-bit dividend, four bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module sch_mod import sch_pkg::*; #(
  parameter int unsigned RW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mod_req_t      req_i,
  input  logic [RW-1:0] divisor_i,
  output logic          done_o,
  output logic [RW-1:0] rem_o
);

  logic          active_q, active_d;
  logic          done_q, done_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [63:0]   div_q, div_d;
  logic [RW-1:0] rem_q, rem_d;

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [63:0]   d;
    r = rem_q;
    d = div_q;
    for (int k = 0; k < 4; k++) begin
      t = {r, d[63]};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
      end
      r = t[RW-1:0];
      d = {d[62:0], 1'b0};
    end
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    div_d    = div_q;
    rem_d    = rem_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = req_i.nibbles;
      div_d    = req_i.dividend;
      rem_d    = '0;
    end else if (active_q) begin
      div_d = d;
      rem_d = r;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/spatial_cell_hash_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial cell hash table unit
// Maps a signed 2-D grid cell key to a storage section through a chained
// hash table held in single-port synchronous memories.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | beat
//  in      | in  | in_valid/in_ready    | in_item_t  (opcode, key, value)
//  out     | out | out_valid/out_ready  | out_item_t (found, value, status)
//  cfg     | in  | cfg_we               | table_size, 13 bits
//
//  Hash: the X multiply, the Y multiply, an issue step and the remainder.
//  Each chain hop: a link remainder, a read and an evaluate step; each probe:
//  a read and an evaluate step. The remainder unit and the memory port set
//  the pace. Reset and clear sweep the used bits, all TABLE_DEPTH entries,
//  no beat taken. A finished result waits in the output register and the next
//  beat is taken; while that register is still full, the next result holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spatial_cell_hash_table_unit import sch_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned LINK_BITS   = 8,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  localparam int unsigned IW  = $clog2(TABLE_DEPTH);
  localparam int unsigned SZW = IW + 1;
  localparam int unsigned LB  = LINK_BITS;
  localparam int unsigned VSW = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int unsigned LSW = ((IW > LB) ? IW : LB) + 1;
  localparam int unsigned LN  = (LSW + 3) / 4;

  typedef struct packed {
    logic           chained;
    logic [LB-1:0]  link;
    logic [31:0]    key_x;
    logic [31:0]    key_y;
    logic [VSW-1:0] value;
  } entry_t;

  function automatic logic [63:0] link_div(input logic [IW-1:0] sl,
                                           input logic [LB-1:0] ln);
    logic [LSW-1:0] sum;
    sum = LSW'(sl) + LSW'(ln);
    return 64'(sum) << (64 - 4 * LN);
  endfunction

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  logic [31:0]   kx_q, kx_d, ky_q, ky_d, px_q, px_d, h_q, h_d;
  logic [VSW-1:0] nv_q, nv_d;
  logic [IW-1:0] s_q, s_d, c_q, c_d, dst_q, dst_d, src_q, src_d, clr_q, clr_d;
  entry_t        dent_q, dent_d;
  logic [LB-1:0] pidx_q, pidx_d;
  logic [SZW-1:0] steps_q, steps_d;
  out_item_t     res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [12:0]   cfg_q;

  entry_t        ent_mem [TABLE_DEPTH];
  logic          used_mem [TABLE_DEPTH];
  entry_t        ent_rd_q, ent_wd;
  logic          used_rd_q, used_wd, used_we, ent_we, rd_en;
  logic [IW-1:0] rd_addr, wr_addr;

  mod_req_t      mod_req;
  logic          mod_done;
  logic [SZW-1:0] mod_rem;

  logic [31:0]   cfg_ext, eff32, mul_a, mul_b, mul_p;
  logic [SZW-1:0] eff_size, steps_inc, c_inc;
  logic [IW-1:0] c_nxt;
  logic          steps_end, probe_last, key_hit, clr_done, in_acc;
  act_e          act;

  assign cfg_ext  = 32'(cfg_q);
  assign eff32    = (cfg_ext < 32'd2) ? 32'd2 :
                    (cfg_ext > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : cfg_ext;
  assign eff_size = eff32[SZW-1:0];

  assign mul_a = (state_q == S_MULX) ? kx_q : ky_q;
  assign mul_b = (state_q == S_MULX) ? PRIME_X : PRIME_Y;
  assign mul_p = mul_a * mul_b;

  assign steps_inc  = steps_q + SZW'(1);
  assign steps_end  = (steps_inc == eff_size);
  assign c_inc      = SZW'(c_q) + SZW'(1);
  assign c_nxt      = (c_inc == eff_size) ? '0 : c_inc[IW-1:0];
  assign probe_last = (pidx_q == {LB{1'b1}});
  assign key_hit    = (ent_rd_q.key_x == kx_q) && (ent_rd_q.key_y == ky_q);
  assign clr_done   = (clr_q == IW'(TABLE_DEPTH - 1));
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    act = ACT_MISS;
    if (!used_rd_q) begin
      act = (op_q == OP_INSERT) ? ACT_FILL : ACT_MISS;
    end else if (key_hit) begin
      case (op_q)
        OP_LOOKUP: act = ACT_HIT;
        OP_INSERT: act = ACT_UPDATE;
        OP_REMOVE: act = ent_rd_q.chained ? ACT_PULL : ACT_FREE;
        default:   act = ACT_MISS;
      endcase
    end else if (ent_rd_q.chained) begin
      if (steps_end) begin
        act = (op_q == OP_INSERT) ? ACT_FULL : ACT_MISS;
      end else begin
        act = ACT_NEXT;
      end
    end else begin
      act = (op_q == OP_INSERT) ? ACT_PROBE : ACT_MISS;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:   if (clr_done) state_d = S_IDLE;
      S_CLEAR:  if (clr_done) state_d = S_FINISH;
      S_IDLE: begin
        if (in_acc) begin
          state_d = (op_e'(in_item_i.opcode) == OP_CLEAR) ? S_CLEAR : S_MULX;
        end
      end
      S_MULX:   state_d = S_MULY;
      S_MULY:   state_d = S_HASH;
      S_HASH:   state_d = S_MWAIT;
      S_MWAIT:  if (mod_done) state_d = S_READ;
      S_READ:   state_d = S_EVAL;
      S_EVAL: begin
        case (act)
          ACT_NEXT:  state_d = S_MWAIT;
          ACT_PROBE: state_d = S_PRD;
          ACT_PULL:  state_d = S_UWAIT;
          default:   state_d = S_FINISH;
        endcase
      end
      S_PRD:    state_d = S_PEV;
      S_PEV: begin
        if (!used_rd_q) begin
          state_d = S_PLINK;
        end else if (probe_last) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_PRD;
        end
      end
      S_PLINK:  state_d = S_FINISH;
      S_UWAIT:  if (mod_done) state_d = S_URD;
      S_URD:    state_d = S_UEV;
      S_UEV:    state_d = (!ent_rd_q.chained || steps_end) ? S_UFREE : S_UWAIT;
      S_UFREE:  state_d = S_FINISH;
      S_FINISH: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_INIT;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    op_d        = op_q;
    kx_d        = kx_q;
    ky_d        = ky_q;
    nv_d        = nv_q;
    px_d        = px_q;
    h_d         = h_q;
    s_d         = s_q;
    c_d         = c_q;
    dst_d       = dst_q;
    src_d       = src_q;
    dent_d      = dent_q;
    pidx_d      = pidx_q;
    steps_d     = steps_q;
    res_d       = res_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    used_we     = 1'b0;
    used_wd     = 1'b0;
    ent_we      = 1'b0;
    ent_wd      = ent_rd_q;
    wr_addr     = s_q;
    rd_en       = 1'b0;
    rd_addr     = s_q;
    mod_req     = '{start: 1'b0, dividend: link_div(s_q, ent_rd_q.link), nibbles: 5'(LN)};
    case (state_q)
      S_INIT, S_CLEAR: begin
        used_we = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_done ? '0 : clr_q + IW'(1);
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          op_d    = op_e'(in_item_i.opcode);
          kx_d    = in_item_i.cell_x;
          ky_d    = in_item_i.cell_y;
          nv_d    = in_item_i.new_value[VSW-1:0];
          steps_d = '0;
          res_d   = '0;
        end
      end
      S_MULX: px_d = mul_p;
      S_MULY: h_d  = px_q ^ mul_p;
      S_HASH: begin
        mod_req = '{start: 1'b1, dividend: {{32{h_q[31]}}, h_q}, nibbles: HASH_NIBBLES};
      end
      S_MWAIT: if (mod_done) s_d = mod_rem[IW-1:0];
      S_READ:  rd_en = 1'b1;
      S_EVAL: begin
        case (act)
          ACT_MISS: res_d.status = STS_MISS;
          ACT_FULL: res_d.status = STS_FULL;
          ACT_HIT: begin
            res_d.found     = 1'b1;
            res_d.value_out = 16'(ent_rd_q.value);
          end
          ACT_FILL: begin
            used_we = 1'b1;
            used_wd = 1'b1;
            ent_we  = 1'b1;
            ent_wd  = '{chained: 1'b0, link: ent_rd_q.link, key_x: kx_q,
                        key_y: ky_q, value: nv_q};
          end
          ACT_UPDATE: begin
            ent_we       = 1'b1;
            ent_wd.value = nv_q;
          end
          ACT_FREE: used_we = 1'b1;
          ACT_NEXT: begin
            steps_d       = steps_inc;
            mod_req.start = 1'b1;
          end
          ACT_PROBE: begin
            dent_d = ent_rd_q;
            c_d    = s_q;
            pidx_d = LB'(1);
          end
          ACT_PULL: begin
            dent_d        = ent_rd_q;
            dst_d         = s_q;
            steps_d       = '0;
            mod_req.start = 1'b1;
          end
          default: res_d.status = STS_MISS;
        endcase
      end
      S_PRD: begin
        rd_en   = 1'b1;
        rd_addr = c_nxt;
        c_d     = c_nxt;
      end
      S_PEV: begin
        wr_addr = c_q;
        if (!used_rd_q) begin
          used_we = 1'b1;
          used_wd = 1'b1;
          ent_we  = 1'b1;
          ent_wd  = '{chained: 1'b0, link: ent_rd_q.link, key_x: kx_q,
                      key_y: ky_q, value: nv_q};
        end else if (probe_last) begin
          res_d.status = STS_FULL;
        end else begin
          pidx_d = pidx_q + LB'(1);
        end
      end
      S_PLINK: begin
        ent_we         = 1'b1;
        ent_wd         = dent_q;
        ent_wd.chained = 1'b1;
        ent_wd.link    = pidx_q;
      end
      S_UWAIT: if (mod_done) src_d = mod_rem[IW-1:0];
      S_URD: begin
        rd_en   = 1'b1;
        rd_addr = src_q;
      end
      S_UEV: begin
        used_we     = 1'b1;
        used_wd     = used_rd_q;
        ent_we      = 1'b1;
        wr_addr     = dst_q;
        ent_wd.link = dent_q.link;
        steps_d     = steps_inc;
        if (ent_rd_q.chained && !steps_end) begin
          dst_d   = src_q;
          dent_d  = ent_rd_q;
          mod_req = '{start: 1'b1, dividend: link_div(src_q, ent_rd_q.link),
                      nibbles: 5'(LN)};
        end
      end
      S_UFREE: begin
        used_we = 1'b1;
        wr_addr = src_q;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  sch_mod #(
    .RW(SZW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .divisor_i(eff_size),
    .done_o   (mod_done),
    .rem_o    (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[wr_addr] <= used_wd;
    if (ent_we) ent_mem[wr_addr] <= ent_wd;
    if (rd_en) begin
      used_rd_q <= used_mem[rd_addr];
      ent_rd_q  <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= CFG_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    kx_q    <= kx_d;
    ky_q    <= ky_d;
    nv_q    <= nv_d;
    px_q    <= px_d;
    h_q     <= h_d;
    s_q     <= s_d;
    c_q     <= c_d;
    dst_q   <= dst_d;
    src_q   <= src_d;
    dent_q  <= dent_d;
    pidx_q  <= pidx_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_IMPL(a_mod_done_waits, mod_done, state_q == S_MWAIT || state_q == S_UWAIT, "remainder done outside wait")
  `ASSERT_IMPL(a_slot_in_range, state_q == S_READ, SZW'(s_q) < eff_size, "slot beyond table size")
  `ASSERT_IMPL(a_probe_nonzero, state_q == S_PRD || state_q == S_PEV, pidx_q != '0, "probe offset zero")
  `ASSERT_IMPL(a_walk_bounded, state_q == S_EVAL || state_q == S_UEV, steps_q < eff_size, "walk overran table size")
  `ASSERT_NEXT(a_finish_loads, state_q == S_FINISH && (!out_valid_q || out_ready_i), out_valid_q, "result beat lost")

endmodule

/* tb/tb_spatial_cell_hash_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial cell hash table unit testbench
// Drives lookup, insert, remove and clear beats through the valid/ready input
// channel and checks every result beat against a behavioral model of the
// chained table, across several table sizes and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_spatial_cell_hash_table_unit;
  import sch_pkg::*;

  localparam int unsigned DEPTH      = 4096;
  localparam int unsigned PROBE_MAX  = 255;
  localparam int unsigned WDOG_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  spatial_cell_hash_table_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table model
  logic        tbl_used    [DEPTH];
  logic        tbl_chained [DEPTH];
  logic [7:0]  tbl_link    [DEPTH];
  logic [31:0] tbl_kx      [DEPTH];
  logic [31:0] tbl_ky      [DEPTH];
  logic [15:0] tbl_val     [DEPTH];
  logic [12:0] size_reg;

  in_item_t  pending_beats[$];
  out_item_t expected_results[$];
  int        fail_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_send = 1'b0;
  int        quiet_cycles = 0;
  int        in_acc_cnt = 0;
  int        in_sent_cnt = 0;
  logic [31:0] key_pool_x[$];
  logic [31:0] key_pool_y[$];

  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_used[i] = 0; tbl_chained[i] = 0; tbl_link[i] = 0;
      tbl_kx[i] = 0; tbl_ky[i] = 0; tbl_val[i] = 0;
    end
  endfunction

  function automatic int unsigned eff_size();
    int unsigned s;
    s = size_reg;
    if (s < 2) s = 2;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic int unsigned home_of(logic [31:0] kx, logic [31:0] ky, int unsigned sz);
    logic [31:0] px;
    logic [31:0] py;
    logic [63:0] h;
    px = kx * PRIME_X;
    py = ky * PRIME_Y;
    h = {{32{px[31]}}, px} ^ {{32{py[31]}}, py};
    return int'(h % 64'(sz));
  endfunction

  function automatic int unsigned hop(int unsigned s, int unsigned sz);
    return (s + tbl_link[s]) % sz;
  endfunction

  function automatic status_e insert_key(logic [31:0] kx, logic [31:0] ky, logic [15:0] v,
                                         int unsigned sz);
    int unsigned s;
    int unsigned c;
    s = home_of(kx, ky, sz);
    for (int unsigned st = 0; st < sz; st++) begin
      if (!tbl_used[s]) begin
        tbl_used[s] = 1; tbl_chained[s] = 0; tbl_kx[s] = kx; tbl_ky[s] = ky; tbl_val[s] = v;
        return STS_DONE;
      end
      if (tbl_kx[s] == kx && tbl_ky[s] == ky) begin
        tbl_val[s] = v;
        return STS_DONE;
      end
      if (tbl_chained[s]) begin
        s = hop(s, sz);
        continue;
      end
      for (int unsigned i = 1; i <= PROBE_MAX; i++) begin
        c = (s + i) % sz;
        if (!tbl_used[c]) begin
          tbl_used[c] = 1; tbl_chained[c] = 0; tbl_kx[c] = kx; tbl_ky[c] = ky; tbl_val[c] = v;
          tbl_link[s] = i[7:0];
          tbl_chained[s] = 1;
          return STS_DONE;
        end
      end
      return STS_FULL;
    end
    return STS_FULL;
  endfunction

  function automatic void pull_up(int unsigned h, int unsigned sz);
    int unsigned dst;
    int unsigned src;
    int unsigned st;
    logic more;
    dst = h;
    src = hop(h, sz);
    st = 0;
    forever begin
      more = tbl_chained[src];
      tbl_used[dst] = tbl_used[src];
      tbl_chained[dst] = more;
      tbl_kx[dst] = tbl_kx[src];
      tbl_ky[dst] = tbl_ky[src];
      tbl_val[dst] = tbl_val[src];
      st++;
      if (!more || st >= sz) break;
      dst = src;
      src = hop(src, sz);
    end
    tbl_used[src] = 0;
  endfunction

  function automatic out_item_t apply_beat(in_item_t b);
    out_item_t r;
    int unsigned sz;
    int unsigned s;
    logic done;
    r = '0;
    sz = eff_size();
    s = home_of(b.cell_x, b.cell_y, sz);
    done = 0;
    case (op_e'(b.opcode))
      OP_LOOKUP: begin
        r.status = STS_MISS;
        for (int unsigned st = 0; st < sz && !done; st++) begin
          if (!tbl_used[s]) done = 1;
          else if (tbl_kx[s] == b.cell_x && tbl_ky[s] == b.cell_y) begin
            r.found = 1; r.value_out = tbl_val[s]; r.status = STS_DONE; done = 1;
          end else if (!tbl_chained[s]) done = 1;
          else s = hop(s, sz);
        end
      end
      OP_INSERT: r.status = insert_key(b.cell_x, b.cell_y, b.new_value, sz);
      OP_REMOVE: begin
        r.status = STS_MISS;
        for (int unsigned st = 0; st < sz && !done; st++) begin
          if (!tbl_used[s]) done = 1;
          else if (tbl_kx[s] == b.cell_x && tbl_ky[s] == b.cell_y) begin
            if (tbl_chained[s]) pull_up(s, sz);
            else tbl_used[s] = 0;
            r.status = STS_DONE; done = 1;
          end else if (!tbl_chained[s]) done = 1;
          else s = hop(s, sz);
        end
      end
      default: wipe_table();
    endcase
    return r;
  endfunction

  function automatic void add_beat(in_item_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && (in_acc_cnt != in_sent_cnt)) begin
        // hold
      end else if (pending_beats.size() > 0 && !hold_send &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_item_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
        in_sent_cnt <= in_sent_cnt + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_r;
    logic      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(), apply_beat(in_item_i));
        in_acc_cnt <= in_acc_cnt + 1;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat %p", out_item_o);
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item_o.found !== exp_r.found) begin
            $error("found: expected %0d actual %0d", exp_r.found, out_item_o.found);
            fail_cnt++;
          end
          if (out_item_o.value_out !== exp_r.value_out) begin
            $error("value_out: expected %0d actual %0d", exp_r.value_out, out_item_o.value_out);
            fail_cnt++;
          end
          if (out_item_o.status !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_item_o.status);
            fail_cnt++;
          end
        end
      end
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_beat(op_e op, logic [31:0] kx, logic [31:0] ky,
                                         logic [15:0] v);
    in_item_t b;
    b.opcode = op; b.cell_x = kx; b.cell_y = ky; b.new_value = v;
    return b;
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DEPTH + 200) @(posedge clk_i);
  endtask

  task automatic set_size(logic [12:0] sz);
    @(negedge clk_i);
    cfg_wdata_i <= sz;
    cfg_we_i <= 1'b1;
    size_reg = sz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t random_beat();
    int unsigned k;
    int unsigned r;
    logic [31:0] kx;
    logic [31:0] ky;
    r = $urandom_range(99);
    if (key_pool_x.size() > 0 && r < 75) begin
      k = $urandom_range(key_pool_x.size() - 1);
      kx = key_pool_x[k]; ky = key_pool_y[k];
    end else begin
      kx = $urandom(); ky = $urandom();
      if (key_pool_x.size() < 40) begin
        key_pool_x.insert(key_pool_x.size(), kx);
        key_pool_y.insert(key_pool_y.size(), ky);
      end
    end
    r = $urandom_range(99);
    if (r < 45) return make_beat(OP_INSERT, kx, ky, 16'($urandom()));
    if (r < 75) return make_beat(OP_LOOKUP, kx, ky, 16'($urandom()));
    if (r < 98) return make_beat(OP_REMOVE, kx, ky, 16'($urandom()));
    return make_beat(OP_CLEAR, kx, ky, 16'($urandom()));
  endfunction

  initial begin
    logic [12:0] sizes[5];
    int          idle_tab[4][2];
    size_reg = CFG_RESET;
    wipe_table();
    sizes = '{13'd0, 13'd1, 13'd4, 13'd8191, 13'd37};
    idle_tab = '{'{0, 0}, '{54, 0}, '{0, 54}, '{28, 28}};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    add_beat(make_beat(OP_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0));
    add_beat(make_beat(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    add_beat(make_beat(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
    add_beat(make_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 16'hA5A5));
    add_beat(make_beat(OP_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0));
    add_beat(make_beat(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5A5A));
    add_beat(make_beat(OP_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0));
    add_beat(make_beat(OP_REMOVE, 32'h1234, 32'h5678, 16'h0));
    add_beat(make_beat(OP_REMOVE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0));
    add_beat(make_beat(OP_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0));
    add_beat(make_beat(OP_CLEAR, 32'h0, 32'h0, 16'h0));
    add_beat(make_beat(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0));
    drain();

    // tiny table: chains, pulls, full
    set_size(13'd1);
    for (int i = 0; i < 6; i++)
      add_beat(make_beat(OP_INSERT, 32'(i), 32'(-i), 16'(i + 1)));
    add_beat(make_beat(OP_REMOVE, 32'd0, 32'd0, 16'h0));
    add_beat(make_beat(OP_LOOKUP, 32'd1, 32'hFFFF_FFFF, 16'h0));
    add_beat(make_beat(OP_REMOVE, 32'd1, 32'hFFFF_FFFF, 16'h0));
    add_beat(make_beat(OP_LOOKUP, 32'd1, 32'hFFFF_FFFF, 16'h0));
    add_beat(make_beat(OP_CLEAR, 32'h0, 32'h0, 16'h0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_size(sizes[ph % 5]);
      send_idle_pct = idle_tab[ph % 4][0];
      recv_stall_pct = idle_tab[ph % 4][1];
      for (int n = 0; n < 50; n++) begin
        add_beat(random_beat());
        if (ph == 3 && n == 25) begin
          while (pending_beats.size() > 0 || in_valid_i) @(posedge clk_i);
          hold_send = 1'b1;
          while (expected_results.size() > 0) @(posedge clk_i);
          hold_send = 1'b0;
        end
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
